// ===== sv/sitr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the signed integer to radix text block.
// No dependencies; every other file of the block uses this package.
package sitr_pkg;

  // Field and register widths
  localparam int unsigned NUM_W          = 32;
  localparam int unsigned SYM_W          = 8;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned RADIX_REG_W    = 5;
  localparam int unsigned SYMS_PER_REG   = CFG_DATA_W / SYM_W;
  localparam int unsigned MAX_DIGITS_DEF = 16;

  // Digit stack holds every digit of the largest magnitude in the smallest radix
  localparam int unsigned STACK_DEPTH    = NUM_W;

  // Divider retires two dividend bits per cycle
  localparam int unsigned DIV_STEPS      = NUM_W / 2;

  // Smallest usable radix
  localparam logic [RADIX_REG_W-1:0] RADIX_MIN = RADIX_REG_W'(2);

  // Character codes
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_MIN   = 8'd32;
  localparam logic [SYM_W-1:0] CHAR_LIMIT = 8'd127;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYM_LOW  = 2'd0,
    CFG_SYM_HIGH = 2'd1,
    CFG_RADIX    = 2'd2
  } sitr_cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SIGN,
    ST_DIV,
    ST_EMIT
  } sitr_state_e;

  // Alphabet check result
  typedef struct packed {
    logic done;
    logic ok;
  } sitr_chk_res_t;

  // Digit stack command
  typedef struct packed {
    logic push;
    logic pop;
  } sitr_stk_cmd_t;

endpackage

// ===== sv/sitr_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the number requests and the text symbols.
// Depends on sitr_pkg for the field widths.
interface sitr_num_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitr_pkg::NUM_W-1:0]   number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sitr_sym_if;
  logic                          valid;
  logic                          ready;
  logic [sitr_pkg::SYM_W-1:0]    symbol;
  logic                          last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ===== sv/sitr_alpha_check.sv =====
`timescale 1ns / 1ps
// Serial alphabet checker: range and sign checks at start, then one rotation
// of the symbol table per cycle to find duplicates. Depends on sitr_pkg.
module sitr_alpha_check #(
  parameter int unsigned MAX_DIGITS = sitr_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sitr_pkg::SYM_W-1:0]       sym_i [MAX_DIGITS],
  input  logic [sitr_pkg::RADIX_REG_W-1:0] radix_i,
  output sitr_pkg::sitr_chk_res_t          res_o
);
  import sitr_pkg::*;

  localparam int unsigned OFF_W = $clog2(MAX_DIGITS);
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(MAX_DIGITS - 1);

  logic [MAX_DIGITS-1:0] used;
  logic [MAX_DIGITS-1:0] used_rot;
  logic [MAX_DIGITS-1:0] sym_bad;
  logic [MAX_DIGITS-1:0] dup;
  logic                  radix_bad;

  logic [SYM_W-1:0]      rot_q [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] rotu_q;
  logic [OFF_W-1:0]      off_q;
  logic                  busy_q;
  logic                  bad_q;
  sitr_chk_res_t         res_q;

  // Per-symbol checks against the table and its rotated copy
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_lane
    localparam int unsigned NEXT = (k + 1) % MAX_DIGITS;
    assign used[k]     = (RADIX_REG_W'(k) < radix_i);
    assign used_rot[k] = (RADIX_REG_W'(NEXT) < radix_i);
    assign sym_bad[k]  = used[k] && ((sym_i[k] == CHAR_PLUS) || (sym_i[k] == CHAR_MINUS) ||
                                     (sym_i[k] < CHAR_MIN) || (sym_i[k] >= CHAR_LIMIT));
    assign dup[k]      = used[k] && rotu_q[k] && (sym_i[k] == rot_q[k]);

    // Rotate the copy by one symbol each cycle
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rot_q[k] <= sym_i[NEXT];
      end else if (busy_q) begin
        rot_q[k] <= rot_q[NEXT];
      end
    end
  end

  assign radix_bad = (radix_i < RADIX_MIN) || (radix_i > RADIX_REG_W'(MAX_DIGITS));

  // Rotate the in-use mask along with the symbols
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rotu_q <= used_rot;
    end else if (busy_q) begin
      rotu_q <= {rotu_q[0], rotu_q[MAX_DIGITS-1:1]};
    end
  end

  // Sweep offsets one to MAX_DIGITS-1, then report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      off_q  <= '0;
      bad_q  <= 1'b0;
      res_q  <= '0;
    end else begin
      res_q.done <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        off_q  <= OFF_W'(1);
        bad_q  <= radix_bad | (|sym_bad);
      end else if (busy_q) begin
        bad_q <= bad_q | (|dup);
        off_q <= off_q + OFF_W'(1);
        if (off_q == LAST_OFF) begin
          busy_q     <= 1'b0;
          res_q.done <= 1'b1;
          res_q.ok   <= !(bad_q | (|dup));
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/sitr_div_unit.sv =====
`timescale 1ns / 1ps
// Radix-4 serial divider: divides the magnitude by the radix, two dividend bits
// per cycle, quotient shifted into the dividend register. Depends on sitr_pkg.
module sitr_div_unit #(
  parameter int unsigned MAX_DIGITS = sitr_pkg::MAX_DIGITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [sitr_pkg::NUM_W-1:0]                dividend_i,
  input  logic [sitr_pkg::RADIX_REG_W-1:0]          divisor_i,
  output logic                                      done_o,
  output logic [sitr_pkg::NUM_W-1:0]                quot_o,
  output logic [$clog2(MAX_DIGITS)-1:0]             rem_o
);
  import sitr_pkg::*;

  localparam int unsigned DW     = $clog2(MAX_DIGITS);
  localparam int unsigned RW     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CW     = RW + 2;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [NUM_W-1:0]  acc_q;
  logic [DW-1:0]     rem_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [CW-1:0] part;
  logic [CW-1:0] d1;
  logic [CW-1:0] d2;
  logic [CW-1:0] d3;
  logic [CW-1:0] diff;
  logic [1:0]    qdig;

  // Pick the quotient digit for the next two bits
  always_comb begin
    d1   = CW'(divisor_i[RW-1:0]);
    d2   = d1 << 1;
    d3   = d1 + d2;
    part = CW'({rem_q, acc_q[NUM_W-1 -: 2]});
    priority if (part >= d3) begin
      qdig = 2'd3;
      diff = part - d3;
    end else if (part >= d2) begin
      qdig = 2'd2;
      diff = part - d2;
    end else if (part >= d1) begin
      qdig = 2'd1;
      diff = part - d1;
    end else begin
      qdig = 2'd0;
      diff = part;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-3:0], qdig};
      rem_q <= diff[DW-1:0];
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

  // The remainder always ends below the divisor
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (CW'(rem_q) < d1))
    else $error("divider remainder not below divisor");

endmodule

// ===== sv/sitr_digit_stack.sv =====
`timescale 1ns / 1ps
// Digit stack built as a shift register: push shifts in at the top, pop shifts
// toward it, so digits leave most significant first. Depends on sitr_pkg.
module sitr_digit_stack #(
  parameter int unsigned DW = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sitr_pkg::sitr_stk_cmd_t cmd_i,
  input  logic [DW-1:0]           digit_i,
  output logic [DW-1:0]           top_o,
  output logic                    single_o
);
  import sitr_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic [DW-1:0]    stk_q [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_q;

  // Shift entries up on push, down on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stk_q[0] <= digit_i;
      for (int k = 1; k < STACK_DEPTH; k++) begin
        stk_q[k] <= stk_q[k-1];
      end
    end else if (cmd_i.pop) begin
      for (int k = 0; k < STACK_DEPTH - 1; k++) begin
        stk_q[k] <= stk_q[k+1];
      end
    end
  end

  // Track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.push) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign top_o    = stk_q[0];
  assign single_o = (cnt_q == CNT_W'(1));

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (cnt_q != CNT_W'(STACK_DEPTH)))
    else $error("digit stack overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (cnt_q != '0) && !cmd_i.push)
    else $error("digit stack underflow or push with pop");

endmodule

// ===== sv/signed_integer_to_radix_text_core.sv =====
`timescale 1ns / 1ps
// Converts a signed 32-bit number to text in a configured radix of up to
// MAX_DIGITS symbols. One number is worked on at a time. Each request first
// runs the alphabet check; an invalid alphabet drops the request with no
// output. A negative number then sends its minus sign first. Each digit comes
// from the radix-4 serial divider, which sets the rate, and each character
// leaves through the output register. The last character may wait in the
// output register while the next number is accepted. Depends on sitr_pkg,
// sitr_stream_if, sitr_alpha_check, sitr_div_unit and sitr_digit_stack.
module signed_integer_to_radix_text_core #(
  parameter int unsigned MAX_DIGITS = sitr_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sitr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sitr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sitr_num_if.sink                        num_i,
  sitr_sym_if.source                      sym_o
);
  import sitr_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DIGITS);

  // Configuration
  logic [SYM_W-1:0]       sym_q [MAX_DIGITS];
  logic [RADIX_REG_W-1:0] radix_q;

  // Sequencer
  sitr_state_e state_q, state_d;
  logic        in_ready;
  logic        accept;
  logic        chk_start;
  logic        div_start;
  sitr_stk_cmd_t stk_cmd;
  logic        out_load;
  logic [SYM_W-1:0] load_sym;
  logic        load_last;

  // Datapath
  logic [NUM_W-1:0] num_raw;
  logic [NUM_W-1:0] mag_q;
  logic             neg_q;
  logic [NUM_W-1:0] dividend;
  sitr_chk_res_t    chk_res;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  logic [DW-1:0]    div_rem;
  logic [DW-1:0]    stk_top;
  logic             stk_single;

  // Output register
  logic             out_valid_q;
  logic [SYM_W-1:0] out_sym_q;
  logic             out_last_q;
  logic             out_free;

  // Symbol table writes, one byte lane per digit value
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_sym
    localparam int unsigned LANE = k % SYMS_PER_REG;
    localparam sitr_cfg_idx_e BANK = (k < SYMS_PER_REG) ? CFG_SYM_LOW : CFG_SYM_HIGH;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sym_q[k] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == BANK)) begin
        sym_q[k] <= cfg_data_i[LANE*SYM_W +: SYM_W];
      end
    end
  end

  // Radix size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_RADIX)) begin
      radix_q <= cfg_data_i[RADIX_REG_W-1:0];
    end
  end

  assign accept   = num_i.valid && in_ready;
  assign num_raw  = num_i.number;
  assign out_free = !out_valid_q || sym_o.ready;
  assign dividend = (state_q == ST_DIV) ? div_quot : mag_q;

  // Capture sign and magnitude of the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= num_raw[NUM_W-1];
      mag_q <= num_raw[NUM_W-1] ? ('0 - num_raw) : num_raw;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control
  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    chk_start = 1'b0;
    div_start = 1'b0;
    stk_cmd   = '0;
    out_load  = 1'b0;
    load_sym  = sym_q[stk_top];
    load_last = stk_single;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (num_i.valid) begin
          chk_start = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_res.done) begin
          if (!chk_res.ok) begin
            state_d = ST_IDLE;
          end else if (neg_q) begin
            state_d = ST_SIGN;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_sym  = CHAR_MINUS;
          load_last = 1'b0;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // Always at least one digit, so zero yields the zero symbol
        if (div_done) begin
          stk_cmd.push = 1'b1;
          if (div_quot == '0) begin
            state_d = ST_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          stk_cmd.pop = 1'b1;
          if (stk_single) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load a character, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (sym_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sym_q  <= load_sym;
      out_last_q <= load_last;
    end
  end

  assign num_i.ready       = in_ready;
  assign sym_o.valid       = out_valid_q;
  assign sym_o.symbol      = out_sym_q;
  assign sym_o.last_symbol = out_last_q;

  sitr_alpha_check #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (chk_start),
    .sym_i   (sym_q),
    .radix_i (radix_q),
    .res_o   (chk_res)
  );

  sitr_div_unit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (radix_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  sitr_digit_stack #(
    .DW (DW)
  ) u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (stk_cmd),
    .digit_i  (div_rem),
    .top_o    (stk_top),
    .single_o (stk_single)
  );

  a_chk_done_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_res.done |-> (state_q == ST_CHECK))
    else $error("alphabet check finished outside check state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("division finished outside divide state");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sym_o.valid && !sym_o.ready) |=>
      (sym_o.valid && $stable(sym_o.symbol) && $stable(sym_o.last_symbol)))
    else $error("stalled character changed or dropped");

endmodule
